@@ design/gb5_pkg.sv @@
package gb5_pkg;

    localparam int DATA_W  = 16;
    localparam int COEF_W  = 16;
    localparam int COEF_N  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_W   = 12;
    localparam int HGT_W   = 13;
    localparam int WID_W   = 11;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROUND_SHIFT = 16;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIST1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIST2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIST4   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIST5   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIST8   = 3'd7;

    typedef logic [COEF_W-1:0] coef_t;
    typedef coef_t [COEF_N-1:0] coef_set_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    // squared tap distance to coefficient slot
    function automatic logic [2:0] coef_sel(input int d2);
        logic [2:0] sel;
        case (d2)
            0: sel = 3'd0;
            1: sel = 3'd1;
            2: sel = 3'd2;
            4: sel = 3'd3;
            5: sel = 3'd4;
            8: sel = 3'd5;
            default: sel = 3'd0;
        endcase
        return sel;
    endfunction

endpackage

@@ design/gb5_mac.sv @@
module gb5_mac #(
    parameter int WIN_SIZE = 5,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  gb5_pkg::tag_t                          in_tag,
    output logic                                   in_ready,
    input  logic [PIXEL_BITS-1:0]                  taps [WIN_SIZE*WIN_SIZE],
    input  gb5_pkg::coef_set_t                     coefs,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [gb5_pkg::DATA_W-1:0]             m_tdata,  // pixel_out
    output logic                                   m_tlast   // frame_last
);

    localparam int NT = WIN_SIZE * WIN_SIZE;
    localparam int H = WIN_SIZE / 2;
    localparam int PW = PIXEL_BITS + gb5_pkg::COEF_W;
    localparam int RSW = PW + $clog2(WIN_SIZE);
    localparam int TW = RSW + $clog2(WIN_SIZE);
    localparam logic [TW:0] PIX_MAX = (TW + 1)'((1 << PIXEL_BITS) - 1);
    localparam logic [TW:0] HALF_LSB = (TW + 1)'(1 << (gb5_pkg::ROUND_SHIFT - 1));

    gb5_pkg::tag_t   c_tag_reg, d_tag_reg, e_tag_reg;
    logic [PW-1:0]   c_prod_reg [NT];
    logic [RSW-1:0]  d_rsum_reg [WIN_SIZE];
    logic [TW-1:0]   e_sum_reg;
    logic            m_valid_reg, m_last_reg;
    logic [PIXEL_BITS-1:0] m_data_reg;
    logic            rdy_out, rdy_e, rdy_d;
    logic [RSW-1:0]  rsum_next [WIN_SIZE];
    logic [TW-1:0]   sum_next;
    logic [TW:0]     rnd;
    logic [PIXEL_BITS-1:0] sat;

    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy_e    = !e_tag_reg.valid || rdy_out;
    assign rdy_d    = !d_tag_reg.valid || rdy_e;
    assign in_ready = !c_tag_reg.valid || rdy_d;

    always_comb begin
        for (int r = 0; r < WIN_SIZE; r++) begin
            rsum_next[r] = '0;
            for (int c = 0; c < WIN_SIZE; c++) begin
                rsum_next[r] = rsum_next[r] + RSW'(c_prod_reg[r*WIN_SIZE+c]);
            end
        end
        sum_next = '0;
        for (int r = 0; r < WIN_SIZE; r++) begin
            sum_next = sum_next + TW'(d_rsum_reg[r]);
        end
        rnd = ({1'b0, e_sum_reg} + HALF_LSB) >> gb5_pkg::ROUND_SHIFT;
        sat = (rnd > PIX_MAX) ? PIX_MAX[PIXEL_BITS-1:0] : rnd[PIXEL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            for (int r = 0; r < WIN_SIZE; r++) begin
                for (int c = 0; c < WIN_SIZE; c++) begin
                    c_prod_reg[r*WIN_SIZE+c] <= PW'(taps[r*WIN_SIZE+c])
                        * PW'(coefs[gb5_pkg::coef_sel((r-H)*(r-H) + (c-H)*(c-H))]);
                end
            end
        end
        if (rdy_d) begin
            d_rsum_reg <= rsum_next;
        end
        if (rdy_e) begin
            e_sum_reg <= sum_next;
        end
        if (rdy_out) begin
            m_data_reg <= sat;
            m_last_reg <= e_tag_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_tag_reg <= '0;
            d_tag_reg <= '0;
            e_tag_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_ready) c_tag_reg <= in_tag;
            if (rdy_d) d_tag_reg <= c_tag_reg;
            if (rdy_e) e_tag_reg <= d_tag_reg;
            if (rdy_out) m_valid_reg <= e_tag_reg.valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = gb5_pkg::DATA_W'(m_data_reg);
    assign m_tlast  = m_last_reg;

endmodule

@@ design/gaussian_blur_5x5_clamp_edge.sv @@
// pipeline: a result is valid on m_tvalid after the tap address, store read, product,
// row sum, total and output registers, unless m_tready stalls the pipeline
// throughput: one request per cycle while s_tready is high; the line store is copied per
// kernel column and row bank so all taps of one result are read in the same cycle
// reset: synchronous active-low aresetn clears counters, pipeline valids and loads default
// size 5x5 and the sigma=1 weights; line store contents are not cleared
module gaussian_blur_5x5_clamp_edge #(
    parameter int WIN_SIZE = 5,
    parameter int MAX_WIDTH = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gb5_pkg::DATA_W-1:0]        s_tdata,   // pixel_in
    input  logic                              s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gb5_pkg::DATA_W-1:0]        m_tdata,   // pixel_out
    output logic                              m_tlast,   // frame_last
    input  logic                              cfg_wr_en,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gb5_pkg::COEF_W-1:0]        cfg_wdata
);

    localparam int H   = WIN_SIZE / 2;
    localparam int SR  = WIN_SIZE + 1;
    localparam int NT  = WIN_SIZE * WIN_SIZE;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int BW  = $clog2(SR);
    localparam int SBW = $clog2(SR + 2 * H + 1);
    localparam int RW  = gb5_pkg::ROW_W;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = PIXEL_BITS'((1 << PIXEL_BITS) - 1);

    logic [gb5_pkg::WID_W-1:0] width_reg;
    logic [gb5_pkg::HGT_W-1:0] height_reg;
    gb5_pkg::coef_set_t        coef_reg;

    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [BW-1:0] in_bank_reg, in_bank_next, out_bank_reg, out_bank_next;
    logic          in_done_reg, in_done_next;

    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic          accept, push, emit, last, restart_cfg;
    logic          rdy_a, rdy_b, mac_ready;
    logic [CW-1:0] wr_col;
    logic [BW-1:0] wr_bank;
    logic [PIXEL_BITS-1:0] wr_pix;
    logic [CW:0]   col_need;
    logic [RW:0]   row_need;

    logic          v_a_reg, v_b_reg, a_last_reg, b_last_reg;
    logic [CW-1:0] a_cc_reg [WIN_SIZE];
    logic [BW-1:0] a_bank_reg [WIN_SIZE];
    logic [BW-1:0] b_bank_reg [WIN_SIZE];
    logic [CW-1:0] cc_next [WIN_SIZE];
    logic [BW-1:0] bank_next [WIN_SIZE];
    logic [PIXEL_BITS-1:0] b_dat [WIN_SIZE][SR];
    logic [PIXEL_BITS-1:0] taps [NT];
    gb5_pkg::tag_t mac_tag;

    // effective frame size
    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (gb5_pkg::HGT_W'(width_reg) > gb5_pkg::HGT_W'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(width_reg - 1'b1);
        end
        if (height_reg == '0) begin
            hm1 = '0;
        end else if (height_reg > gb5_pkg::HGT_W'(gb5_pkg::MAX_HEIGHT)) begin
            hm1 = RW'(gb5_pkg::MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(height_reg - 1'b1);
        end
    end

    assign s_tready = rdy_a;
    assign accept = s_tvalid && s_tready;
    assign push = accept && (s_tuser == gb5_pkg::CMD_PUSH);
    assign restart_cfg = cfg_wr_en && (cfg_index == gb5_pkg::REG_IMAGE_WIDTH
                                     || cfg_index == gb5_pkg::REG_IMAGE_HEIGHT);
    assign wr_pix = (s_tdata > gb5_pkg::DATA_W'(PIX_MAX)) ? PIX_MAX : PIXEL_BITS'(s_tdata);

    // position bookkeeping and readiness of the next output
    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        in_bank_next = in_bank_reg;
        out_bank_next = out_bank_reg;
        in_done_next = in_done_reg;
        if (push && in_done_reg) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            in_bank_next = '0;
            out_bank_next = '0;
            in_done_next = 1'b0;
        end
        wr_col  = in_col_next;
        wr_bank = in_bank_next;
        if (push) begin
            if (in_col_next == wm1) begin
                in_col_next = '0;
                if (in_row_next == hm1) begin
                    in_row_next  = '0;
                    in_bank_next = '0;
                    in_done_next = 1'b1;
                end else begin
                    in_row_next  = in_row_next + 1'b1;
                    in_bank_next = (in_bank_next == BW'(SR - 1)) ? '0 : in_bank_next + 1'b1;
                end
            end else begin
                in_col_next = in_col_next + 1'b1;
            end
        end

        col_need = (CW + 1)'(out_col_next) + (CW + 1)'(H);
        if (col_need > {1'b0, wm1}) col_need = {1'b0, wm1};
        row_need = (RW + 1)'(out_row_next) + (RW + 1)'(H);
        emit = accept && (in_done_next
                          || !((row_need > {1'b0, in_row_next})
                               || (row_need == {1'b0, in_row_next}
                                   && col_need >= {1'b0, in_col_next})));
        last = (out_row_next == hm1) && (out_col_next == wm1);

        for (int d = 0; d < WIN_SIZE; d++) begin
            logic [CW:0]   ct;
            logic [RW:0]   rt;
            logic [RW:0]   rr;
            logic [SBW-1:0] off;
            logic [SBW-1:0] s;
            ct = (CW + 1)'(out_col_next) + (CW + 1)'(d);
            if (ct < (CW + 1)'(H)) begin
                cc_next[d] = '0;
            end else if (ct - (CW + 1)'(H) > {1'b0, wm1}) begin
                cc_next[d] = wm1;
            end else begin
                cc_next[d] = CW'(ct - (CW + 1)'(H));
            end
            rt = (RW + 1)'(out_row_next) + (RW + 1)'(d);
            if (rt < (RW + 1)'(H)) begin
                rr = '0;
            end else if (rt - (RW + 1)'(H) > {1'b0, hm1}) begin
                rr = {1'b0, hm1};
            end else begin
                rr = rt - (RW + 1)'(H);
            end
            off = SBW'(rr + (RW + 1)'(H) - (RW + 1)'(out_row_next));
            s = SBW'(out_bank_next) + off;
            if (s < SBW'(H)) begin
                bank_next[d] = BW'(s + SBW'(SR) - SBW'(H));
            end else if (s - SBW'(H) >= SBW'(SR)) begin
                bank_next[d] = BW'(s - SBW'(H) - SBW'(SR));
            end else begin
                bank_next[d] = BW'(s - SBW'(H));
            end
        end

        if (emit) begin
            if (last) begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
                in_bank_next = '0;
                out_bank_next = '0;
                in_done_next = 1'b0;
            end else if (out_col_next == wm1) begin
                out_col_next = '0;
                out_row_next = out_row_next + 1'b1;
                out_bank_next = (out_bank_next == BW'(SR - 1)) ? '0 : out_bank_next + 1'b1;
            end else begin
                out_col_next = out_col_next + 1'b1;
            end
        end
        if (restart_cfg) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            in_bank_next = '0;
            out_bank_next = '0;
            in_done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gb5_pkg::WID_W'(5);
            height_reg <= gb5_pkg::HGT_W'(5);
            coef_reg[0] <= 16'd10624;
            coef_reg[1] <= 16'd6444;
            coef_reg[2] <= 16'd3908;
            coef_reg[3] <= 16'd1438;
            coef_reg[4] <= 16'd872;
            coef_reg[5] <= 16'd195;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            in_bank_reg <= '0;
            out_bank_reg <= '0;
            in_done_reg <= 1'b0;
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    gb5_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[gb5_pkg::WID_W-1:0];
                    gb5_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[gb5_pkg::HGT_W-1:0];
                    gb5_pkg::REG_COEF_CENTER:  coef_reg[0] <= cfg_wdata;
                    gb5_pkg::REG_COEF_DIST1:   coef_reg[1] <= cfg_wdata;
                    gb5_pkg::REG_COEF_DIST2:   coef_reg[2] <= cfg_wdata;
                    gb5_pkg::REG_COEF_DIST4:   coef_reg[3] <= cfg_wdata;
                    gb5_pkg::REG_COEF_DIST5:   coef_reg[4] <= cfg_wdata;
                    gb5_pkg::REG_COEF_DIST8:   coef_reg[5] <= cfg_wdata;
                    default: ;
                endcase
            end
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            in_bank_reg <= in_bank_next;
            out_bank_reg <= out_bank_next;
            in_done_reg <= in_done_next;
            if (rdy_a) v_a_reg <= emit;
            if (rdy_b) v_b_reg <= v_a_reg;
        end
    end

    // tap addresses, then store read
    assign rdy_b = !v_b_reg || mac_ready;
    assign rdy_a = !v_a_reg || rdy_b;

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_cc_reg   <= cc_next;
            a_bank_reg <= bank_next;
            a_last_reg <= last;
        end
        if (rdy_b) begin
            b_bank_reg <= a_bank_reg;
            b_last_reg <= a_last_reg;
        end
    end

    for (genvar gx = 0; gx < WIN_SIZE; gx++) begin : g_col
        for (genvar gb = 0; gb < SR; gb++) begin : g_bank
            logic [PIXEL_BITS-1:0] store_mem [MAX_WIDTH];
            logic [PIXEL_BITS-1:0] rd_reg;
            always_ff @(posedge aclk) begin
                if (push && wr_bank == BW'(gb)) begin
                    store_mem[wr_col] <= wr_pix;
                end
                if (rdy_b) begin
                    rd_reg <= store_mem[a_cc_reg[gx]];
                end
            end
            assign b_dat[gx][gb] = rd_reg;
        end
    end

    always_comb begin
        for (int r = 0; r < WIN_SIZE; r++) begin
            for (int c = 0; c < WIN_SIZE; c++) begin
                taps[r*WIN_SIZE+c] = b_dat[c][b_bank_reg[r]];
            end
        end
    end

    assign mac_tag.valid = v_b_reg;
    assign mac_tag.last  = b_last_reg;

    gb5_mac #(
        .WIN_SIZE(WIN_SIZE),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_mac (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_tag(mac_tag),
        .in_ready(mac_ready),
        .taps(taps),
        .coefs(coef_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

endmodule

@@ test/gaussian_blur_5x5_clamp_edge_tb.sv @@
`timescale 1ns / 1ps

module gaussian_blur_5x5_clamp_edge_tb;

    localparam int STORE_W   = 1024;
    localparam int STORE_R   = 6;
    localparam int LIMIT     = 400000;
    localparam int SETTLE    = 24;
    localparam int IDX_W     = gb5_pkg::CFG_IDX_W;

    typedef struct {
        logic [15:0] pix;
        logic        last;
    } blur_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = gb5_pkg::CMD_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = gb5_pkg::REG_IMAGE_WIDTH;
    logic [15:0] cfg_wdata = '0;

    // blur model state
    logic [15:0] pix_store [0:STORE_R*STORE_W-1];
    int unsigned row_in, col_in, row_out, col_out;
    bit          frame_in_done;
    int unsigned img_w_reg, img_h_reg;
    int unsigned weights [0:5];

    blur_out_t   blur_q [$];
    blur_out_t   got;
    blur_out_t   want;
    int          fails = 0;
    int          results_seen = 0;
    int          requests_sent = 0;
    int          frames_done = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold = 0;

    gaussian_blur_5x5_clamp_edge u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void frame_restart();
        row_in = 0;
        col_in = 0;
        row_out = 0;
        col_out = 0;
        frame_in_done = 1'b0;
    endfunction

    function automatic int unsigned eff_w();
        return (img_w_reg < 1) ? 1 : (img_w_reg > 1024) ? 1024 : img_w_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h_reg < 1) ? 1 :
               (img_h_reg > gb5_pkg::MAX_HEIGHT) ? gb5_pkg::MAX_HEIGHT : img_h_reg;
    endfunction

    function automatic int unsigned tap_weight(int d2);
        case (d2)
            0: return weights[0];
            1: return weights[1];
            2: return weights[2];
            4: return weights[3];
            5: return weights[4];
            8: return weights[5];
            default: return 0;
        endcase
    endfunction

    function automatic void blur_cfg(logic [IDX_W-1:0] idx, logic [15:0] val);
        if (idx == gb5_pkg::REG_IMAGE_WIDTH) begin
            img_w_reg = val & 16'h07ff;
            frame_restart();
        end else if (idx == gb5_pkg::REG_IMAGE_HEIGHT) begin
            img_h_reg = val & 16'h1fff;
            frame_restart();
        end else begin
            weights[idx - gb5_pkg::REG_COEF_CENTER] = val;
        end
    endfunction

    function automatic bit blur_step(logic cmd, logic [15:0] pix, output blur_out_t res);
        int unsigned w, h, col_need;
        longint unsigned have, need, acc;
        int rr, cc;
        bit last;
        w = eff_w();
        h = eff_h();
        acc = 0;
        res.pix = '0;
        res.last = 1'b0;
        if (cmd == gb5_pkg::CMD_PUSH) begin
            if (frame_in_done) frame_restart();
            pix_store[(row_in % STORE_R) * STORE_W + (col_in % STORE_W)] = pix;
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
                if (row_in >= h) begin
                    row_in = 0;
                    frame_in_done = 1'b1;
                end
            end
        end
        have = frame_in_done ? longint'(w) * h : longint'(row_in) * w + col_in;
        col_need = col_out + 2;
        if (col_need > w - 1) col_need = w - 1;
        need = longint'(row_out + 2) * w + col_need;
        if (!frame_in_done && need >= have) return 0;
        for (int dy = -2; dy <= 2; dy++) begin
            rr = int'(row_out) + dy;
            if (rr < 0) rr = 0;
            if (rr > int'(h) - 1) rr = int'(h) - 1;
            for (int dx = -2; dx <= 2; dx++) begin
                cc = int'(col_out) + dx;
                if (cc < 0) cc = 0;
                if (cc > int'(w) - 1) cc = int'(w) - 1;
                acc += longint'(pix_store[(rr % STORE_R) * STORE_W + (cc % STORE_W)])
                       * tap_weight(dy * dy + dx * dx);
            end
        end
        acc = (acc + 32768) >> 16;
        res.pix = (acc > 65535) ? 16'hffff : acc[15:0];
        last = (row_out == h - 1) && (col_out == w - 1);
        res.last = last;
        if (last) begin
            frame_restart();
        end else begin
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out++;
            end
        end
        return 1;
    endfunction

    // predict on every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (blur_step(s_tuser, s_tdata, want)) blur_q.push_back(want);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.pix = m_tdata;
            got.last = m_tlast;
            results_seen++;
            if (got.last) frames_done++;
            if (blur_q.size() == 0) begin
                $display("%0t unexpected result: actual pix=%h last=%b",
                         $time, got.pix, got.last);
                fails++;
            end else begin
                want = blur_q.pop_front();
                if (got.pix !== want.pix || got.last !== want.last) begin
                    $display("%0t mismatch: expected pix=%h last=%b actual pix=%h last=%b",
                             $time, want.pix, want.last, got.pix, got.last);
                    fails++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom % 100) >= rx_idle_pct;
        end
    end

    task automatic send_req(logic cmd, logic [15:0] pix);
        forever begin
            @(negedge aclk);
            if (($urandom % 100) < tx_idle_pct) s_tvalid <= 1'b0;
            else break;
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (blur_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        blur_cfg(idx, val);
    endtask

    function automatic logic [15:0] rand_pix();
        case ($urandom % 4)
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic set_size(int w, int h);
        wait_idle();
        write_cfg(gb5_pkg::REG_IMAGE_WIDTH, 16'(w));
        write_cfg(gb5_pkg::REG_IMAGE_HEIGHT, 16'(h));
    endtask

    // whole frame of pushes with drains mixed in, then drains to flush
    task automatic run_frame(int w, int h, int drain_pct);
        for (int i = 0; i < w * h; i++) begin
            if (($urandom % 100) < drain_pct) send_req(gb5_pkg::CMD_DRAIN, 16'($urandom));
            send_req(gb5_pkg::CMD_PUSH, rand_pix());
        end
        repeat (w * h + 2) send_req(gb5_pkg::CMD_DRAIN, 16'($urandom));
    endtask

    task automatic test_default_frame();
        send_req(gb5_pkg::CMD_DRAIN, 16'h1234);
        for (int i = 0; i < 25; i++) begin
            send_req(gb5_pkg::CMD_PUSH,
                     (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0000 : 16'(i));
        end
        repeat (8) send_req(gb5_pkg::CMD_DRAIN, 16'hffff);
        wait_idle();
    endtask

    task automatic test_coef_extremes();
        for (int k = 0; k < 6; k++) begin
            write_cfg(IDX_W'(gb5_pkg::REG_COEF_CENTER + k), 16'hffff);
        end
        set_size(3, 2);
        run_frame(3, 2, 0);
        wait_idle();
        for (int k = 0; k < 6; k++) begin
            write_cfg(IDX_W'(gb5_pkg::REG_COEF_CENTER + k), 16'h0000);
        end
        run_frame(3, 2, 0);
        wait_idle();
        write_cfg(gb5_pkg::REG_COEF_CENTER, 16'd10624);
        write_cfg(gb5_pkg::REG_COEF_DIST1, 16'd6444);
        write_cfg(gb5_pkg::REG_COEF_DIST2, 16'd3908);
        write_cfg(gb5_pkg::REG_COEF_DIST4, 16'd1438);
        write_cfg(gb5_pkg::REG_COEF_DIST5, 16'd872);
        write_cfg(gb5_pkg::REG_COEF_DIST8, 16'd195);
    endtask

    task automatic test_size_edges();
        set_size(1, 1);
        run_frame(1, 1, 50);
        set_size(0, 0);
        run_frame(1, 1, 0);
        // widths and heights beyond the limit saturate; frame left partial
        set_size(16'h07ff, 1);
        repeat (10) send_req(gb5_pkg::CMD_PUSH, rand_pix());
        send_req(gb5_pkg::CMD_DRAIN, 16'h0000);
        set_size(1, 16'h1fff);
        repeat (12) send_req(gb5_pkg::CMD_PUSH, rand_pix());
        repeat (4) send_req(gb5_pkg::CMD_DRAIN, 16'h0000);
        // full frame received, pending outputs dropped by a new push
        set_size(4, 3);
        repeat (12) send_req(gb5_pkg::CMD_PUSH, rand_pix());
        run_frame(4, 3, 10);
        wait_idle();
    endtask

    task automatic test_random_frames(int n_req);
        int start;
        int w, h;
        start = requests_sent;
        while (requests_sent - start < n_req) begin
            w = ($urandom % 8 == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_size(w, h);
            if ($urandom % 2) begin
                write_cfg(IDX_W'(gb5_pkg::REG_COEF_CENTER + $urandom_range(0, 5)),
                          16'($urandom));
            end
            if ($urandom % 5 == 0) begin
                repeat ($urandom_range(1, w * h)) send_req(gb5_pkg::CMD_PUSH, rand_pix());
                repeat ($urandom_range(0, 6)) send_req(gb5_pkg::CMD_DRAIN, 16'($urandom));
            end else begin
                run_frame(w, h, 15);
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_size(8, 8);
        @(posedge aclk);
        rx_hold = 400;
        run_frame(8, 8, 0);
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < STORE_R * STORE_W; i++) pix_store[i] = '0;
        img_w_reg = 5;
        img_h_reg = 5;
        weights = '{10624, 6444, 3908, 1438, 872, 195};
        frame_restart();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 58;
        test_default_frame();
        test_coef_extremes();
        test_size_edges();
        test_backpressure();
        test_random_frames(100);
        tx_idle_pct = 58;
        rx_idle_pct = 16;
        test_random_frames(100);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(100);
        $display("covered %0d requests, %0d results, %0d complete frames",
                 requests_sent, results_seen, frames_done);
        $display("sizes from 1x1 to saturated limits, coefficient extremes, long stall");
        if (fails == 0 && blur_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
